[sv/move_to_front_table_defines.svh]
// assertion macros for the move-to-front table
// used by move_to_front_table.sv; expects i_clk and i_rst_n in scope
`ifndef MOVE_TO_FRONT_TABLE_DEFINES_SVH
`define MOVE_TO_FRONT_TABLE_DEFINES_SVH

// same-cycle implication, held off while in reset
`define MTF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("move_to_front_table: check failed");

// next-cycle implication, held off while in reset
`define MTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("move_to_front_table: check failed");

`endif

[sv/mtf_pkg.sv]
// shared types and codes for the move-to-front table
// no dependencies; imported by mtf_cell and move_to_front_table
`default_nettype none

package mtf_pkg;

    localparam int KEY_W = 32;

    // request command codes
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // control broadcast to every cell
    typedef struct packed {
        logic capture;   // latch compare result for a new request
        logic shift_all; // append: every cell takes its neighbour's key
        logic shift_hit; // search hit: cells up to the first match shift
    } t_cell_ctl;

endpackage

`default_nettype wire

[sv/mtf_cell.sv]
// one table cell: holds a key, compares it and shifts it back on request
// depends on mtf_pkg
`default_nettype none

module mtf_cell
    import mtf_pkg::*;
(
    input  wire             i_clk,
    input  wire t_cell_ctl  i_ctl,
    input  wire [KEY_W-1:0] i_cmp_key,
    input  wire [KEY_W-1:0] i_prev_key,
    input  wire             i_valid,
    input  wire             i_seen,
    output logic            o_seen,
    output logic            o_first,
    output logic [KEY_W-1:0] o_key
);

    logic [KEY_W-1:0] r_data;
    logic             r_match;
    logic             shift;

    // a cell shifts on a hit only if no match sits ahead of it
    assign shift   = i_ctl.shift_all | (i_ctl.shift_hit & ~i_seen);
    assign o_seen  = i_seen | r_match;
    assign o_first = r_match & ~i_seen;
    assign o_key   = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= i_valid & (r_data == i_cmp_key);
        end
        if (shift) begin
            r_data <= i_prev_key;
        end
    end

endmodule

`default_nettype wire

[sv/move_to_front_table.sv]
// move-to-front table: a row of key cells with a shared command sequencer
// depends on mtf_pkg, mtf_cell and move_to_front_table_defines.svh
//
// usage
//   a request (i_cmd, i_key) is taken at a rising edge where start is high
//   and busy is low. append puts the key at the front unless the table is
//   full, search moves the first matching entry to the front, clear empties
//   the table.
//   every request gives exactly one result on o_status, o_hit_position and
//   o_entry_count, shown for one cycle with o_strobe high. the receiver
//   cannot stall, so the result is taken in that cycle.
// timing
//   the acceptance edge latches the compare of every cell at once; the next
//   edge ripples the first-match flag along the cells, shifts the keys and
//   registers the result. o_strobe is high in the cycle after that, and
//   busy is high for the one cycle in between, so a new request can be
//   accepted in the cycle the strobe is shown.
// reset
//   i_rst_n low at a rising edge empties the table and drops busy and
//   o_strobe; the key cells themselves are not cleared.
`default_nettype none

module move_to_front_table
    import mtf_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  wire [1:0]        i_cmd,
    input  wire [KEY_W-1:0]  i_key,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [3:0]       o_hit_position,
    output logic [4:0]       o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);

    logic             r_busy;
    logic             r_strobe;
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic [PW-1:0]    r_pos;
    logic [PW-1:0]    n_pos;

    logic             accept;
    logic             full;
    logic             hit_any;
    logic [PW-1:0]    hit_idx;
    t_cell_ctl        ctl;

    logic [KEY_W-1:0] cell_key [CAPACITY];
    logic             seen_link [CAPACITY+1];
    logic             first_flag [CAPACITY];

    logic [PW+3:0]    pos_ext;
    logic [CW+4:0]    count_ext;

    assign accept = start & ~r_busy;
    assign busy   = r_busy;
    assign full   = (r_count == CW'(CAPACITY));
    assign hit_any = seen_link[CAPACITY];

    assign ctl.capture   = accept;
    assign ctl.shift_all = r_busy & (r_cmd == CMD_APPEND) & ~full;
    assign ctl.shift_hit = r_busy & (r_cmd == CMD_SEARCH) & hit_any;

    assign seen_link[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [KEY_W-1:0] prev_key;
            if (gi == 0) begin : g_front
                assign prev_key = r_key;
            end else begin : g_back
                assign prev_key = cell_key[gi-1];
            end
            mtf_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_cmp_key  (i_key),
                .i_prev_key (prev_key),
                .i_valid    (CW'(gi) < r_count),
                .i_seen     (seen_link[gi]),
                .o_seen     (seen_link[gi+1]),
                .o_first    (first_flag[gi]),
                .o_key      (cell_key[gi])
            );
        end
    endgenerate

    // at most one cell flags first match, so an or of indices encodes it
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_flag[i]) begin
                hit_idx = hit_idx | PW'(i);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_pos    = '0;
        unique case (r_cmd)
            CMD_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_SEARCH: begin
                if (hit_any) begin
                    n_pos = hit_idx;
                end else begin
                    n_status = ST_MISS;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_busy   <= accept;
            r_strobe <= r_busy;
            if (r_busy) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
        end
        if (r_busy) begin
            r_status <= n_status;
            r_pos    <= n_pos;
        end
    end

    // fields are reported masked to their widths
    assign pos_ext   = {4'b0, r_pos};
    assign count_ext = {5'b0, r_count};

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_hit_position = pos_ext[3:0];
    assign o_entry_count  = count_ext[4:0];

`include "move_to_front_table_defines.svh"

    `MTF_ASSERT_NEXT(a_result_follows, r_busy, o_strobe)
    `MTF_ASSERT_NEXT(a_accept_busy, accept, r_busy && !o_strobe)
    `MTF_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY))
    `MTF_ASSERT_NOW(a_miss_no_pos, o_strobe && (o_status == ST_MISS), o_hit_position == 4'd0)
    `MTF_ASSERT_NEXT(a_full_keeps, r_busy && (r_cmd == CMD_APPEND) && full,
                     r_count == CW'(CAPACITY) && o_status == ST_FULL)

endmodule

`default_nettype wire
